// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/hhlp_pkg.sv -----
// Package for the HTTP header line parser: parse states, result codes,
// framing characters and default limits. No dependencies.
package hhlp_pkg;

  localparam int MAX_VALUE_DEF = 255;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_KEY    = 4'd1,
    ST_COLON  = 4'd2,
    ST_SPACE  = 4'd3,
    ST_VALUE  = 4'd4,
    ST_CR     = 4'd5,
    ST_LF     = 4'd6,
    ST_END_CR = 4'd7,
    ST_BODY   = 4'd8,
    ST_FAIL   = 4'd9
  } state_t;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_VALUE = 2'd2,
    KIND_BODY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_PARSING  = 2'd0,
    STAT_COMPLETE = 2'd1,
    STAT_FAILED   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_KEY_BREAK = 3'd1,
    ERR_NO_SPACE  = 3'd2,
    ERR_VAL_LONG  = 3'd3,
    ERR_BAD_EOL   = 3'd4
  } err_t;

endpackage

// ----- sv/hhlp_in_if.sv -----
// Input channel of the HTTP header line parser: one raw byte per item.
// Standalone valid/ready interface, no dependencies.
interface hhlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       new_request;

  modport source (output valid, output byte_in, output new_request, input ready);
  modport sink   (input valid, input byte_in, input new_request, output ready);
endinterface

// ----- sv/hhlp_out_if.sv -----
// Result channel of the HTTP header line parser: one classified byte per item.
// Standalone valid/ready interface, no dependencies.
interface hhlp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [1:0] kind;
  logic       pair_done;
  logic [1:0] status;
  logic [2:0] error_code;

  modport source (output valid, output byte_out, output kind, output pair_done,
                  output status, output error_code, input ready);
  modport sink   (input valid, input byte_out, input kind, input pair_done,
                  input status, input error_code, output ready);
endinterface

// ----- sv/http_header_line_parser.sv -----
// HTTP header line parser top level: parse state machine and result register.
// Depends on hhlp_pkg, hhlp_in_if, hhlp_out_if and assert_macros.svh.
//
// Classifies the header section one byte per clock unless stalled. Each
// accepted item yields exactly one result item, held in a result register;
// a new byte is accepted whenever that register is empty or being taken, so
// an unstalled stream runs at one item per cycle. The only feedback path is
// the parse state, value length counter and fault code, updated in the cycle
// of acceptance. new_request restarts parsing with the byte it arrives with.
// MAX_VALUE sets the longest value (MAX_VALUE+1 bytes) and the counter width.
`include "assert_macros.svh"

module http_header_line_parser #(
  parameter int MAX_VALUE = hhlp_pkg::MAX_VALUE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hhlp_in_if.sink   in_ch,
  hhlp_out_if.source out_ch
);

  localparam int CW = $clog2(MAX_VALUE + 2);

  hhlp_pkg::state_t state_r, state_nxt, state_cur;
  logic [CW-1:0]    count_r, count_nxt, count_cur;
  logic [2:0]       fault_r, fault_nxt, fault_cur;

  logic             out_valid_r;
  logic [7:0]       byte_r;
  logic [1:0]       kind_r, kind_nxt;
  logic             pair_r, pair_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [2:0]       err_r, err_nxt;

  logic             in_take;
  logic [7:0]       b;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_in;

  always_comb begin
    state_cur = in_ch.new_request ? hhlp_pkg::ST_START : state_r;
    count_cur = in_ch.new_request ? '0 : count_r;
    fault_cur = in_ch.new_request ? hhlp_pkg::ERR_NONE : fault_r;

    state_nxt = state_cur;
    count_nxt = count_cur;
    fault_nxt = fault_cur;
    kind_nxt  = hhlp_pkg::KIND_FRAME;
    pair_nxt  = 1'b0;

    case (state_cur)
      hhlp_pkg::ST_START: begin
        if (b != hhlp_pkg::CH_CR && b != hhlp_pkg::CH_LF) begin
          state_nxt = hhlp_pkg::ST_KEY;
          kind_nxt  = hhlp_pkg::KIND_KEY;
        end
      end
      hhlp_pkg::ST_KEY: begin
        if (b == hhlp_pkg::CH_COLON) begin
          state_nxt = hhlp_pkg::ST_COLON;
        end else if (b == hhlp_pkg::CH_CR || b == hhlp_pkg::CH_LF) begin
          state_nxt = hhlp_pkg::ST_FAIL;
          fault_nxt = hhlp_pkg::ERR_KEY_BREAK;
        end else begin
          kind_nxt = hhlp_pkg::KIND_KEY;
        end
      end
      hhlp_pkg::ST_COLON: begin
        if (b == hhlp_pkg::CH_SPACE) begin
          state_nxt = hhlp_pkg::ST_SPACE;
        end else begin
          state_nxt = hhlp_pkg::ST_FAIL;
          fault_nxt = hhlp_pkg::ERR_NO_SPACE;
        end
      end
      hhlp_pkg::ST_SPACE: begin
        state_nxt = hhlp_pkg::ST_VALUE;
        count_nxt = CW'(1);
        kind_nxt  = hhlp_pkg::KIND_VALUE;
      end
      hhlp_pkg::ST_VALUE: begin
        if (b == hhlp_pkg::CH_CR) begin
          state_nxt = hhlp_pkg::ST_CR;
        end else if (count_cur > CW'(MAX_VALUE)) begin
          state_nxt = hhlp_pkg::ST_FAIL;
          fault_nxt = hhlp_pkg::ERR_VAL_LONG;
        end else begin
          count_nxt = CW'(count_cur + 1'b1);
          kind_nxt  = hhlp_pkg::KIND_VALUE;
        end
      end
      hhlp_pkg::ST_CR: begin
        if (b == hhlp_pkg::CH_LF) begin
          state_nxt = hhlp_pkg::ST_LF;
          pair_nxt  = 1'b1;
        end else begin
          state_nxt = hhlp_pkg::ST_FAIL;
          fault_nxt = hhlp_pkg::ERR_BAD_EOL;
        end
      end
      hhlp_pkg::ST_LF: begin
        if (b == hhlp_pkg::CH_CR) begin
          state_nxt = hhlp_pkg::ST_END_CR;
        end else begin
          state_nxt = hhlp_pkg::ST_KEY;
          kind_nxt  = hhlp_pkg::KIND_KEY;
        end
      end
      hhlp_pkg::ST_END_CR: begin
        if (b == hhlp_pkg::CH_LF) begin
          state_nxt = hhlp_pkg::ST_BODY;
        end else begin
          state_nxt = hhlp_pkg::ST_FAIL;
          fault_nxt = hhlp_pkg::ERR_BAD_EOL;
        end
      end
      hhlp_pkg::ST_BODY: begin
        kind_nxt = hhlp_pkg::KIND_BODY;
      end
      default: begin
        state_nxt = hhlp_pkg::ST_FAIL;
      end
    endcase

    if (state_nxt == hhlp_pkg::ST_BODY) begin
      status_nxt = hhlp_pkg::STAT_COMPLETE;
      err_nxt    = hhlp_pkg::ERR_NONE;
    end else if (state_nxt == hhlp_pkg::ST_FAIL) begin
      status_nxt = hhlp_pkg::STAT_FAILED;
      err_nxt    = fault_nxt;
    end else begin
      status_nxt = hhlp_pkg::STAT_PARSING;
      err_nxt    = hhlp_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hhlp_pkg::ST_START;
      count_r     <= '0;
      fault_r     <= hhlp_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        state_r     <= state_nxt;
        count_r     <= count_nxt;
        fault_r     <= fault_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r   <= b;
      kind_r   <= kind_nxt;
      pair_r   <= pair_nxt;
      status_r <= status_nxt;
      err_r    <= err_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.byte_out   = byte_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.pair_done  = pair_r;
  assign out_ch.status     = status_r;
  assign out_ch.error_code = err_r;

  `ASSERT_CLK(a_pair_framing,
    out_valid_r && pair_r |-> kind_r == hhlp_pkg::KIND_FRAME &&
    status_r == hhlp_pkg::STAT_PARSING,
    "pair_done on a non-framing or non-parsing item")
  `ASSERT_ALWAYS(a_fault_in_fail,
    state_r == hhlp_pkg::ST_FAIL |-> fault_r != hhlp_pkg::ERR_NONE,
    "failed state without a fault code")
  `ASSERT_ALWAYS(a_fault_only_fail,
    state_r != hhlp_pkg::ST_FAIL |-> fault_r == hhlp_pkg::ERR_NONE,
    "fault code held outside the failed state")
  `ASSERT_CLK(a_body_sticky,
    in_take && !in_ch.new_request && state_r == hhlp_pkg::ST_BODY |=>
    out_valid_r && kind_r == hhlp_pkg::KIND_BODY && status_r == hhlp_pkg::STAT_COMPLETE,
    "body byte not reported as body")
  `ASSERT_CLK(a_count_bound,
    count_r <= CW'(MAX_VALUE + 1),
    "value length counter past its limit")

endmodule
